FILE: sv/ihc_pkg.sv
// Shared types and constants for the IPv4 header checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihc_pkg;

  localparam int unsigned IDX_W     = 6;   // byte index inside the header, up to 60
  localparam int unsigned HDR_LEN_W = 6;

  localparam logic [HDR_LEN_W-1:0] MIN_HEADER_BYTES = HDR_LEN_W'(20);
  localparam logic [HDR_LEN_W-1:0] MAX_HEADER_BYTES = HDR_LEN_W'(60);
  localparam logic [15:0]          MIN_PACKET_BYTES = 16'd20;
  localparam logic [3:0]           IP_VERSION_4     = 4'd4;

  // Byte positions of the fixed header fields
  localparam logic [IDX_W-1:0] IDX_VER_IHL   = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_TLEN_HI   = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_TLEN_LO   = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_ID_HI     = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_ID_LO     = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_FRAG_HI   = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_FRAG_LO   = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_PROTO     = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_CSUM_HI   = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_CSUM_LO   = IDX_W'(11);
  localparam logic [IDX_W-1:0] IDX_SRC_0     = IDX_W'(12);
  localparam logic [IDX_W-1:0] IDX_SRC_1     = IDX_W'(13);
  localparam logic [IDX_W-1:0] IDX_SRC_2     = IDX_W'(14);
  localparam logic [IDX_W-1:0] IDX_SRC_3     = IDX_W'(15);
  localparam logic [IDX_W-1:0] IDX_DST_0     = IDX_W'(16);
  localparam logic [IDX_W-1:0] IDX_DST_1     = IDX_W'(17);
  localparam logic [IDX_W-1:0] IDX_DST_2     = IDX_W'(18);
  localparam logic [IDX_W-1:0] IDX_DST_3     = IDX_W'(19);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FIELD    = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_DEST     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  pkt_byte;
    logic        pkt_start;
    logic [15:0] buf_size;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [31:0]          src_address;
    logic [7:0]           protocol;
    logic [15:0]          ident;
    logic [15:0]          frag_byte_offset;
    logic                 more_fragments;
    logic                 dont_fragment;
    logic                 unfragmented;
    logic [HDR_LEN_W-1:0] header_bytes;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/ihc_in_stage.sv
// Input register of the IPv4 header checker: holds one packet byte transaction.
// Depends on ihc_pkg.
`default_nettype none

module ihc_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ihc_pkg::in_item_t in_item_i,
  input  wire logic            take_i,     // downstream consumes the held byte
  output logic                 valid_o,
  output ihc_pkg::in_item_t    item_o
);
  import ihc_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ihc_hdr_engine.sv
// Header engine: byte index, running ones-complement sum, field capture and
// the ordered checks that form the verdict. Depends on ihc_pkg.
`default_nettype none

module ihc_hdr_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic              en_i,
  input  wire ihc_pkg::in_item_t item_i,
  output logic                   res_valid_o,
  output ihc_pkg::result_t       res_o
);
  import ihc_pkg::*;

  logic [31:0]          own_addr_q;
  logic                 done_q, done_d;
  logic [IDX_W-1:0]     idx_q, idx_d;

  logic [15:0]          sum_q, sum_d;
  logic [7:0]           hi_q, hi_d;
  logic [HDR_LEN_W-1:0] hlen_q, hlen_d;
  logic                 ver_ok_q, ver_ok_d;
  logic [15:0]          tlen_q, tlen_d;
  logic [15:0]          size_q, size_d;
  logic [15:0]          ident_q, ident_d;
  logic [15:0]          frag_q, frag_d;
  logic [7:0]           proto_q, proto_d;
  logic [15:0]          csum_q, csum_d;
  logic [31:0]          src_q, src_d;
  logic [31:0]          dst_q, dst_d;

  logic                 proc;
  logic                 st;
  logic [7:0]           b;
  logic [IDX_W-1:0]     idx, idx_inc;
  logic [16:0]          sum_wide;
  logic                 len_bad;
  logic                 df, mf, rf;
  logic [15:0]          off;
  status_e              verdict;

  assign st   = item_i.pkt_start;
  assign b    = item_i.pkt_byte;
  assign proc = en_i && (st || !done_q);
  // A start byte sees the byte index and capture state cleared and the buffer size loaded
  assign idx  = st ? '0 : idx_q;
  assign idx_inc = idx + IDX_W'(1);

  always_comb begin
    hi_d     = st ? 8'd0  : hi_q;
    sum_d    = st ? 16'd0 : sum_q;
    hlen_d   = st ? '0    : hlen_q;
    ver_ok_d = st ? 1'b0  : ver_ok_q;
    tlen_d   = st ? 16'd0 : tlen_q;
    size_d   = st ? item_i.buf_size : size_q;
    ident_d  = st ? 16'd0 : ident_q;
    frag_d   = st ? 16'd0 : frag_q;
    proto_d  = st ? 8'd0  : proto_q;
    csum_d   = st ? 16'd0 : csum_q;
    src_d    = st ? 32'd0 : src_q;
    dst_d    = st ? 32'd0 : dst_q;
    sum_wide = {1'b0, sum_d} + {1'b0, hi_d, b};

    if (!idx[0]) begin
      hi_d = b;
    end else if (idx != IDX_CSUM_LO) begin
      // end-around carry
      sum_d = sum_wide[15:0] + {15'd0, sum_wide[16]};
    end

    unique case (idx)
      IDX_VER_IHL: begin
        ver_ok_d = (b[7:4] == IP_VERSION_4);
        hlen_d   = {b[3:0], 2'b00};
      end
      IDX_TLEN_HI, IDX_TLEN_LO: tlen_d  = {tlen_d[7:0], b};
      IDX_ID_HI, IDX_ID_LO:     ident_d = {ident_d[7:0], b};
      IDX_FRAG_HI, IDX_FRAG_LO: frag_d  = {frag_d[7:0], b};
      IDX_PROTO:                proto_d = b;
      IDX_CSUM_HI, IDX_CSUM_LO: csum_d  = {csum_d[7:0], b};
      IDX_SRC_0, IDX_SRC_1, IDX_SRC_2, IDX_SRC_3: src_d = {src_d[23:0], b};
      IDX_DST_0, IDX_DST_1, IDX_DST_2, IDX_DST_3: dst_d = {dst_d[23:0], b};
      default: ;
    endcase
  end

  assign rf  = frag_d[15];
  assign df  = frag_d[14];
  assign mf  = frag_d[13];
  assign off = {frag_d[12:0], 3'b000};

  assign len_bad = (hlen_d < MIN_HEADER_BYTES) || (hlen_d > MAX_HEADER_BYTES);

  always_comb begin
    priority if (idx == IDX_VER_IHL && len_bad) begin
      verdict = ST_FIELD;
    end else if (!ver_ok_d) begin
      verdict = ST_FIELD;
    end else if (tlen_d != size_d || size_d < MIN_PACKET_BYTES) begin
      verdict = ST_FIELD;
    end else if (csum_d != ~sum_d) begin
      verdict = ST_CHECKSUM;
    end else if (dst_d != own_addr_q) begin
      verdict = ST_DEST;
    end else if (rf || (df && mf)) begin
      verdict = ST_FIELD;
    end else begin
      verdict = ST_OK;
    end
  end

  assign res_valid_o = proc && ((idx == IDX_VER_IHL) ? len_bad : (idx_inc == hlen_d));

  assign done_d = proc ? res_valid_o : done_q;
  assign idx_d  = proc ? idx_inc : idx_q;

  always_comb begin
    res_o.status           = verdict;
    res_o.src_address      = src_d;
    res_o.protocol         = proto_d;
    res_o.ident            = ident_d;
    res_o.frag_byte_offset = off;
    res_o.more_fragments   = mf;
    res_o.dont_fragment    = df;
    res_o.unfragmented     = df || (!mf && (off == 16'd0));
    res_o.header_bytes     = hlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 32'd0;
      done_q     <= 1'b1;
      idx_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  // Capture state is only read after a start byte has cleared it
  always_ff @(posedge clk_i) begin
    if (proc) begin
      hi_q     <= hi_d;
      sum_q    <= sum_d;
      hlen_q   <= hlen_d;
      ver_ok_q <= ver_ok_d;
      tlen_q   <= tlen_d;
      size_q   <= size_d;
      ident_q  <= ident_d;
      frag_q   <= frag_d;
      proto_q  <= proto_d;
      csum_q   <= csum_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ihc_out_stage.sv
// Result register of the IPv4 header checker; holds a verdict until taken.
// Depends on ihc_pkg.
`default_nettype none

module ihc_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire ihc_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ihc_pkg::result_t      res_o
);
  import ihc_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ipv4_header_checker_top.sv
// IPv4 header checker, top level: input register, header engine, result register.
// Depends on ihc_pkg, ihc_in_stage, ihc_hdr_engine, ihc_out_stage.
//
// Takes one packet byte per cycle unless stalled, a start mark on the first
// byte of each packet, and gives one verdict per header: when the header
// length in the first byte is outside 20..60, or else after the last header
// byte. Checks apply in order and the first failure sets the status:
// version, total length against the buffer size and a buffer under 20
// bytes, checksum, destination against own_address, reserved/DF+MF flags.
// Bytes before a start mark or after the verdict are accepted and dropped.
// Throughput is one byte per cycle while no verdict waits. The deciding byte
// sits in the input register while the engine's combinational sum and
// compare load the result register. While a verdict waits with out_ready_i
// low, the input register takes at most one more byte and then stalls. Write
// own_address only while no packet is in flight; the block does not check it.
`default_nettype none

module ipv4_header_checker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  pkt_byte_i,
  input  wire logic        pkt_start_i,
  input  wire logic [15:0] buf_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      src_address_o,
  output logic [7:0]       protocol_o,
  output logic [15:0]      ident_o,
  output logic [15:0]      frag_byte_offset_o,
  output logic             more_fragments_o,
  output logic             dont_fragment_o,
  output logic             unfragmented_o,
  output logic [ihc_pkg::HDR_LEN_W-1:0] header_bytes_o
);
  import ihc_pkg::*;

  in_item_t in_item, s1_item;
  logic     s1_valid;
  logic     out_free;
  logic     take;
  logic     res_valid;
  result_t  res, out_res;

  assign in_item.pkt_byte  = pkt_byte_i;
  assign in_item.pkt_start = pkt_start_i;
  assign in_item.buf_size  = buf_size_i;

  assign take = s1_valid && out_free;

  ihc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  ihc_hdr_engine u_eng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .en_i        (take),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign status_o           = out_res.status;
  assign src_address_o      = out_res.src_address;
  assign protocol_o         = out_res.protocol;
  assign ident_o            = out_res.ident;
  assign frag_byte_offset_o = out_res.frag_byte_offset;
  assign more_fragments_o   = out_res.more_fragments;
  assign dont_fragment_o    = out_res.dont_fragment;
  assign unfragmented_o     = out_res.unfragmented;
  assign header_bytes_o     = out_res.header_bytes;

`ifndef SYNTHESIS
  // An accepted header never carries DF and MF together
  a_ok_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> !(dont_fragment_o && more_fragments_o))
    else $error("ok verdict with DF and MF set");

  // Only a field error may report a header length out of range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FIELD |->
      header_bytes_o >= MIN_HEADER_BYTES && header_bytes_o <= MAX_HEADER_BYTES)
    else $error("header length out of range without field error");

  // Offset is in units of eight bytes
  a_off_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frag_byte_offset_o[2:0] == 3'b000)
    else $error("fragment byte offset misaligned");

  // Input side keeps moving while the result register is free
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
